// File: rtl/nrst_pkg.sv
// ----------------------------------------------------------------------------
// nrst_pkg: shared types and constants
// Table sizes, datapath operation codes and controller status bundle.
// ----------------------------------------------------------------------------
package nrst_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int RADIUS_BITS = 16;
  localparam int TOL_W       = 16;
  localparam int ID_W        = 6;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int CMP_W       = (RADIUS_BITS > TOL_W) ? RADIUS_BITS : TOL_W;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_SCAN,
    OP_EVAL,
    OP_DECIDE,
    OP_SHIFT,
    OP_EMIT
  } op_t;

  typedef struct packed {
    logic scan_done;
    logic match;
    logic full;
    logic shift_last;
  } status_t;

endpackage

// File: rtl/nrst_if.sv
// ----------------------------------------------------------------------------
// nrst_if: request and result channels
// Valid/ready channels carrying the lookup request and its result.
// ----------------------------------------------------------------------------
interface nrst_req_if;
  logic        valid;
  logic        ready;
  logic [15:0] req_radius;
  logic [15:0] tolerance;

  modport source (output valid, output req_radius, output tolerance, input ready);
  modport sink (input valid, input req_radius, input tolerance, output ready);
endinterface

interface nrst_res_if;
  logic       valid;
  logic       ready;
  logic [5:0] shape_id;
  logic       created;
  logic       table_full;

  modport source (output valid, output shape_id, output created, output table_full,
                  input ready);
  modport sink (input valid, input shape_id, input created, input table_full,
                output ready);
endinterface

// File: rtl/nrst_datapath.sv
// ----------------------------------------------------------------------------
// nrst_datapath: radius table and search/insert datapath
// Holds the sorted table memory, the scan registers, the nearest-entry
// evaluation and the insertion shifter.
// ----------------------------------------------------------------------------
module nrst_datapath (
  input  logic                  clk,
  input  logic                  rst,
  input  nrst_pkg::op_t         op,
  input  logic [15:0]           req_radius,
  input  logic [15:0]           tolerance,
  output nrst_pkg::status_t     status,
  output logic [5:0]            shape_id,
  output logic                  created,
  output logic                  table_full
);

  logic [nrst_pkg::RADIUS_BITS-1:0] mem_rad [nrst_pkg::TABLE_DEPTH];
  logic [nrst_pkg::ID_W-1:0]        mem_id  [nrst_pkg::TABLE_DEPTH];

  logic [nrst_pkg::RADIUS_BITS-1:0] rd_rad;
  logic [nrst_pkg::ID_W-1:0]        rd_id;
  logic [nrst_pkg::ADDR_W-1:0]      raddr;
  logic                             we;
  logic [nrst_pkg::ADDR_W-1:0]      waddr;
  logic [nrst_pkg::RADIUS_BITS-1:0] wrad;
  logic [nrst_pkg::ID_W-1:0]        wid;

  logic [nrst_pkg::RADIUS_BITS-1:0] req_r;
  logic [nrst_pkg::TOL_W-1:0]       tol_r;
  logic [nrst_pkg::CNT_W-1:0]       cnt;
  logic [nrst_pkg::CNT_W-1:0]       idx;
  logic [nrst_pkg::CNT_W-1:0]       pos;
  logic [nrst_pkg::CNT_W-1:0]       sh;
  logic [nrst_pkg::RADIUS_BITS-1:0] prev_rad;
  logic [nrst_pkg::ID_W-1:0]        prev_id;
  logic [nrst_pkg::RADIUS_BITS-1:0] cur_rad;
  logic [nrst_pkg::ID_W-1:0]        cur_id;
  logic [nrst_pkg::RADIUS_BITS-1:0] gap;
  logic [nrst_pkg::ID_W-1:0]        pick_id;
  logic                             have;
  logic [nrst_pkg::ID_W-1:0]        res_id;
  logic                             res_created;
  logic                             res_full;

  logic                             scan_end;
  logic                             hit;
  logic [nrst_pkg::RADIUS_BITS-1:0] dlo;
  logic [nrst_pkg::RADIUS_BITS-1:0] dhi;
  logic [nrst_pkg::RADIUS_BITS-1:0] gap_next;
  logic [nrst_pkg::ID_W-1:0]        pick_next;

  assign scan_end = (idx == cnt);
  assign hit      = !scan_end && (rd_rad >= req_r);
  assign dlo      = req_r - prev_rad;
  assign dhi      = cur_rad - req_r;

  assign status.scan_done  = scan_end || hit;
  assign status.match      = have &&
                             (nrst_pkg::CMP_W'(gap) < nrst_pkg::CMP_W'(tol_r));
  assign status.full       = (cnt == nrst_pkg::CNT_W'(nrst_pkg::TABLE_DEPTH));
  assign status.shift_last = (sh == pos);

  always_comb begin
    if (pos == cnt) begin
      gap_next  = dlo;
      pick_next = prev_id;
    end else if (pos == '0) begin
      gap_next  = dhi;
      pick_next = cur_id;
    end else if (dlo < dhi) begin
      gap_next  = dlo;
      pick_next = prev_id;
    end else begin
      gap_next  = dhi;
      pick_next = cur_id;
    end
  end

  always_comb begin
    raddr = '0;
    we    = 1'b0;
    waddr = sh[nrst_pkg::ADDR_W-1:0];
    wrad  = rd_rad;
    wid   = rd_id;
    unique case (op)
      nrst_pkg::OP_SCAN:   raddr = nrst_pkg::ADDR_W'(idx + nrst_pkg::CNT_W'(1));
      nrst_pkg::OP_DECIDE: raddr = nrst_pkg::ADDR_W'(cnt - nrst_pkg::CNT_W'(1));
      nrst_pkg::OP_SHIFT: begin
        raddr = nrst_pkg::ADDR_W'(sh - nrst_pkg::CNT_W'(2));
        we    = 1'b1;
        if (status.shift_last) begin
          waddr = pos[nrst_pkg::ADDR_W-1:0];
          wrad  = req_r;
          wid   = cnt[nrst_pkg::ID_W-1:0];
        end
      end
      default: raddr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem_rad[waddr] <= wrad;
      mem_id[waddr]  <= wid;
    end
    rd_rad <= mem_rad[raddr];
    rd_id  <= mem_id[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (op == nrst_pkg::OP_SHIFT && status.shift_last) begin
      cnt <= cnt + nrst_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    unique case (op)
      nrst_pkg::OP_LOAD: begin
        req_r <= req_radius[nrst_pkg::RADIUS_BITS-1:0];
        tol_r <= tolerance;
        idx   <= '0;
      end
      nrst_pkg::OP_SCAN: begin
        if (scan_end) begin
          pos <= cnt;
        end else if (hit) begin
          pos     <= idx;
          cur_rad <= rd_rad;
          cur_id  <= rd_id;
        end else begin
          prev_rad <= rd_rad;
          prev_id  <= rd_id;
          idx      <= idx + nrst_pkg::CNT_W'(1);
        end
      end
      nrst_pkg::OP_EVAL: begin
        gap     <= gap_next;
        pick_id <= pick_next;
        have    <= (cnt != '0);
      end
      nrst_pkg::OP_DECIDE: begin
        sh <= cnt;
        if (status.match) begin
          res_id      <= pick_id;
          res_created <= 1'b0;
          res_full    <= 1'b0;
        end else if (status.full) begin
          res_id      <= pick_id;
          res_created <= 1'b0;
          res_full    <= 1'b1;
        end else begin
          res_id      <= cnt[nrst_pkg::ID_W-1:0];
          res_created <= 1'b1;
          res_full    <= 1'b0;
        end
      end
      nrst_pkg::OP_SHIFT: begin
        if (!status.shift_last) begin
          sh <= sh - nrst_pkg::CNT_W'(1);
        end
      end
      nrst_pkg::OP_EMIT: begin
        shape_id   <= res_id;
        created    <= res_created;
        table_full <= res_full;
      end
      default: begin
      end
    endcase
  end

endmodule

// File: rtl/nrst_ctrl.sv
// ----------------------------------------------------------------------------
// nrst_ctrl: request sequencer
// Steps the datapath through scan, evaluate, decide, insert shift and result
// hand-off, and owns both channel handshakes.
// ----------------------------------------------------------------------------
module nrst_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  nrst_pkg::status_t status,
  output nrst_pkg::op_t     op
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_EVAL,
    S_DECIDE,
    S_SHIFT,
    S_EMIT
  } state_t;

  state_t state;
  logic   emit_ok;

  assign in_ready = (state == S_IDLE);
  assign emit_ok  = !out_valid || out_ready;

  always_comb begin
    unique case (state)
      S_IDLE:   op = in_valid ? nrst_pkg::OP_LOAD : nrst_pkg::OP_NONE;
      S_SCAN:   op = nrst_pkg::OP_SCAN;
      S_EVAL:   op = nrst_pkg::OP_EVAL;
      S_DECIDE: op = nrst_pkg::OP_DECIDE;
      S_SHIFT:  op = nrst_pkg::OP_SHIFT;
      S_EMIT:   op = emit_ok ? nrst_pkg::OP_EMIT : nrst_pkg::OP_NONE;
      default:  op = nrst_pkg::OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (state == S_EMIT && emit_ok) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (status.scan_done) begin
            state <= S_EVAL;
          end
        end
        S_EVAL:   state <= S_DECIDE;
        S_DECIDE: begin
          if (status.match || status.full) begin
            state <= S_EMIT;
          end else begin
            state <= S_SHIFT;
          end
        end
        S_SHIFT: begin
          if (status.shift_last) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (emit_ok) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/nearest_radius_shape_table_top.sv
// ----------------------------------------------------------------------------
// nearest_radius_shape_table_top: nearest-radius shape id table
// Looks up the nearest stored radius within tolerance, or inserts the radius
// in sorted order under a new id, or reports the table full when it cannot.
//
//   channel  dir  payload
//   req      in   req_radius[15:0], tolerance[15:0]
//   res      out  shape_id[5:0], created, table_full
//
// One request at a time; with n entries and p the first entry not below the
// radius (p = n if none), a match or a full-table refusal scans up to entry p,
// and an insert then also shifts entries p to n-1 up one place before the result.
// A new request is taken while a result still waits on res; its own result
// then holds in the emit step until res is free.
// rst clears the entry count; the table contents need no clearing.
// ----------------------------------------------------------------------------
module nearest_radius_shape_table_top (
  input logic       clk,
  input logic       rst,
  nrst_req_if.sink  req,
  nrst_res_if.source res
);

  nrst_pkg::op_t     op;
  nrst_pkg::status_t status;

  nrst_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (res.valid),
    .out_ready (res.ready),
    .status    (status),
    .op        (op)
  );

  nrst_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .op         (op),
    .req_radius (req.req_radius),
    .tolerance  (req.tolerance),
    .status     (status),
    .shape_id   (res.shape_id),
    .created    (res.created),
    .table_full (res.table_full)
  );

`ifndef SYNTH
  a_load_on_accept: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) == (op == nrst_pkg::OP_LOAD))
    else $error("datapath load does not track request accept");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("second request taken while one is in flight");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (op == nrst_pkg::OP_EMIT) |-> (!res.valid || res.ready))
    else $error("result overwritten before it was taken");
`endif

endmodule
